// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the compass heading block.
// No dependencies; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHM_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/chm_pkg.sv =====
// Package of the compass heading block: types, widths, constants and the arctangent table.
// No dependencies; used by compass_heading_moving_average_top.
package chm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_CORDIC,
        ST_FINISH,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        CFG_OFFSET_X = 3'd0,
        CFG_OFFSET_Y = 3'd1,
        CFG_ROT_COS  = 3'd2,
        CFG_ROT_SIN  = 3'd3,
        CFG_Y_SCALE  = 3'd4
    } t_cfg_index;

    localparam int WINDOW_DEPTH_DEF = 256;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int DATA_W     = 16;
    localparam int DIFF_W     = 17;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 34;
    localparam int VEC_W      = 38;
    localparam int ANG_W      = 26;
    localparam int HEAD_W     = 27;
    localparam int UNIT_W     = 18;
    localparam int ATAN_W     = 22;
    localparam int CNT_W      = 5;
    localparam int COEF_FRAC  = 14;
    localparam int UNIT_SHIFT = 9;

    localparam int ATAN_TABLE_LEN = 24;
    localparam int FULL_TURN      = 46080;
    localparam int HALF_TURN_FINE = 11796480;
    localparam int HEAD_ROUND     = 256;

    localparam logic signed [DATA_W-1:0] OFFSET_X_RST = -16'sd1984;
    localparam logic signed [DATA_W-1:0] OFFSET_Y_RST = 16'sd112;
    localparam logic signed [DATA_W-1:0] ROT_COS_RST  = 16'sd15388;
    localparam logic signed [DATA_W-1:0] ROT_SIN_RST  = -16'sd5624;
    localparam logic signed [DATA_W-1:0] Y_SCALE_RST  = 16'sd18583;

    // Rounded arctangent of 2^-i in 1/65536 degree.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/chm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced by compass_heading_moving_average_top for the window store.
module chm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/compass_heading_moving_average_top.sv =====
// Compass heading with moving average: offset removal, rotation, CORDIC atan2, window mean.
// Depends on chm_pkg, chm_ram and assert_macros.svh.
//
// Usage:
// A sample (mag_x, mag_y) arrives as one transfer on the s_axis channel. The block
// removes the hard-iron offsets, rotates and scales the vector with one shared
// multiplier, then runs CORDIC_STEPS vectoring iterations on one shared
// add/shift unit to form heading = 180 - atan2(xc, yc) in 1/128 degree. Steps beyond
// the 24-entry arctangent table are not performed. The heading enters a ring window
// in a RAM, the running total is updated, and one multiplication by the reciprocal of
// the window depth forms the window mean.
// Each result leaves as one transfer on m_axis: heading_now and heading_mean.
// The sequencer takes one sample at a time: it runs the multiplier sequence and then
// the CORDIC iterations; the zero vector skips the iterations.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new sample is taken while the last
// result still waits; when the receiver stalls, the block holds its next result in
// the final step until the output register frees up.
// Reset (synchronous, active low) restores the register defaults, empties the output
// and marks the window as never written, so early means count missing entries as zero.
// Configuration writes are taken at any edge with i_cfg_we; writes beyond the list
// are ignored.
`include "assert_macros.svh"

module compass_heading_moving_average_top #(
    parameter int WINDOW_DEPTH = chm_pkg::WINDOW_DEPTH_DEF,
    parameter int CORDIC_STEPS = chm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [chm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [chm_pkg::DATA_W-1:0]     i_cfg_wdata,
    // Sample input channel.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [15:0] mag_x, [31:16] mag_y
    // Result output channel.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata   // [15:0] heading_now, [31:16] heading_mean
);

    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int TOTAL_W = chm_pkg::DATA_W + SLOT_W;
    localparam int QUO_W   = chm_pkg::DATA_W;
    localparam int STEPS   = (CORDIC_STEPS < chm_pkg::ATAN_TABLE_LEN) ?
                             CORDIC_STEPS : chm_pkg::ATAN_TABLE_LEN;
    localparam int CNT_W   = chm_pkg::CNT_W;

    // Rounded-up reciprocal of the window depth; exact for every total of TOTAL_W bits.
    localparam int     RECIP_SHIFT = TOTAL_W + SLOT_W;
    localparam int     RECIP_W     = TOTAL_W + 1;
    localparam int     MEAN_PROD_W = TOTAL_W + RECIP_W;
    localparam longint RECIP_VAL   =
        ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_DEPTH - 1)) / longint'(WINDOW_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  =
        TOTAL_W'(WINDOW_DEPTH * (chm_pkg::FULL_TURN - 1));
    localparam logic [CNT_W-1:0]   CORDIC_LAST = CNT_W'(STEPS - 1);

    // Multiplier sequence steps.
    localparam logic [CNT_W-1:0] MS_DX_SIN = 5'd0;
    localparam logic [CNT_W-1:0] MS_DY_COS = 5'd1;
    localparam logic [CNT_W-1:0] MS_DX_COS = 5'd2;
    localparam logic [CNT_W-1:0] MS_DY_SIN = 5'd3;
    localparam logic [CNT_W-1:0] MS_SCALE  = 5'd4;
    localparam logic [CNT_W-1:0] MS_LAST   = 5'd5;

    localparam logic signed [chm_pkg::ANG_W-1:0] HALF_ANG =
        chm_pkg::ANG_W'(chm_pkg::HALF_TURN_FINE);
    localparam logic signed [chm_pkg::HEAD_W-1:0] HALF_HEAD =
        chm_pkg::HEAD_W'(chm_pkg::HALF_TURN_FINE);
    localparam logic signed [chm_pkg::UNIT_W-1:0] TURN_UNITS =
        chm_pkg::UNIT_W'(chm_pkg::FULL_TURN);

    chm_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    logic signed [chm_pkg::DATA_W-1:0] r_offset_x, r_offset_y, r_rot_cos, r_rot_sin, r_y_scale;

    logic signed [chm_pkg::DIFF_W-1:0] r_dx, r_dy;
    logic signed [chm_pkg::PROD_W-1:0] r_prod;
    logic signed [chm_pkg::ACC_W-1:0]  r_acc_x, r_acc_y;
    logic signed [chm_pkg::VEC_W-1:0]  r_re, r_im;
    logic signed [chm_pkg::ANG_W-1:0]  r_ang;
    logic [chm_pkg::DATA_W-1:0]        r_now;

    logic [SLOT_W-1:0]  r_slot;
    logic               r_filled;
    logic [TOTAL_W-1:0] r_total;
    logic [QUO_W-1:0]   r_quo;

    logic                      r_out_valid;
    logic [chm_pkg::DATA_W-1:0] r_out_now, r_out_mean;

    // Control decoded from the state.
    logic w_in_ready, w_in_xfer, w_ram_we, w_out_load;

    // Shared multiplier.
    logic signed [chm_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [chm_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [chm_pkg::PROD_W-1:0]  w_prod, w_prod_shr;

    // Shared CORDIC add/shift unit.
    logic signed [chm_pkg::VEC_W-1:0] w_sh_re, w_sh_im;
    logic signed [chm_pkg::ANG_W-1:0] w_atan;

    logic signed [chm_pkg::HEAD_W-1:0] w_head;
    logic signed [chm_pkg::UNIT_W-1:0] w_units, w_units_wrap;

    logic [chm_pkg::DATA_W-1:0] w_ram_rdata, w_old;
    logic [TOTAL_W-1:0]         w_new_total;
    logic [MEAN_PROD_W-1:0]     w_mean_prod;

    chm_ram #(
        .WIDTH (chm_pkg::DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_now),
        .i_raddr (r_slot),
        .o_rdata (w_ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            chm_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = chm_pkg::ST_MUL;
            end
            chm_pkg::ST_MUL: begin
                if (r_cnt == MS_LAST) n_state = chm_pkg::ST_PREP;
            end
            chm_pkg::ST_PREP: begin
                // The zero vector has angle zero and skips the iterations.
                if (r_re == '0 && r_im == '0) n_state = chm_pkg::ST_FINISH;
                else n_state = chm_pkg::ST_CORDIC;
            end
            chm_pkg::ST_CORDIC: begin
                if (r_cnt == CORDIC_LAST) n_state = chm_pkg::ST_FINISH;
            end
            chm_pkg::ST_FINISH: n_state = chm_pkg::ST_UPDATE;
            chm_pkg::ST_UPDATE: n_state = chm_pkg::ST_DIV;
            chm_pkg::ST_DIV:    n_state = chm_pkg::ST_DONE;
            chm_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = chm_pkg::ST_IDLE;
            end
            default: n_state = chm_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        w_in_ready = 1'b0;
        w_ram_we   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            chm_pkg::ST_IDLE:   w_in_ready = 1'b1;
            chm_pkg::ST_UPDATE: w_ram_we   = 1'b1;
            chm_pkg::ST_DONE:   w_out_load = !r_out_valid || m_axis_tready;
            default: begin
            end
        endcase
    end

    assign w_in_xfer = s_axis_tvalid && w_in_ready;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_cnt)
            MS_DX_SIN: begin
                w_mul_a = chm_pkg::MUL_A_W'(r_dx);
                w_mul_b = r_rot_sin;
            end
            MS_DY_COS: begin
                w_mul_a = chm_pkg::MUL_A_W'(r_dy);
                w_mul_b = r_rot_cos;
            end
            MS_DX_COS: begin
                w_mul_a = chm_pkg::MUL_A_W'(r_dx);
                w_mul_b = r_rot_cos;
            end
            MS_DY_SIN: begin
                w_mul_a = chm_pkg::MUL_A_W'(r_dy);
                w_mul_b = r_rot_sin;
            end
            MS_SCALE: begin
                w_mul_a = r_acc_y;
                w_mul_b = r_y_scale;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_shr = r_prod >>> chm_pkg::COEF_FRAC;

    assign w_sh_re = r_re >>> r_cnt;
    assign w_sh_im = r_im >>> r_cnt;
    assign w_atan  = $signed({{(chm_pkg::ANG_W - chm_pkg::ATAN_W){1'b0}},
                              chm_pkg::atan_entry(r_cnt)});

    // Heading in 1/128 degree, rounded, folded once into one full turn.
    assign w_head  = HALF_HEAD - chm_pkg::HEAD_W'(r_ang);
    assign w_units = chm_pkg::UNIT_W'((w_head + chm_pkg::HEAD_W'(chm_pkg::HEAD_ROUND))
                                      >>> chm_pkg::UNIT_SHIFT);
    always_comb begin
        if (w_units < 0) w_units_wrap = w_units + TURN_UNITS;
        else if (w_units >= TURN_UNITS) w_units_wrap = w_units - TURN_UNITS;
        else w_units_wrap = w_units;
    end

    // Entries not yet written since reset read as zero.
    assign w_old       = r_filled ? w_ram_rdata : '0;
    assign w_new_total = r_total - TOTAL_W'(w_old) + TOTAL_W'(r_now);

    // Window mean: the updated total times the reciprocal of the depth.
    assign w_mean_prod = MEAN_PROD_W'(r_total) * MEAN_PROD_W'(RECIP);

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chm_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_filled    <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_offset_x  <= chm_pkg::OFFSET_X_RST;
            r_offset_y  <= chm_pkg::OFFSET_Y_RST;
            r_rot_cos   <= chm_pkg::ROT_COS_RST;
            r_rot_sin   <= chm_pkg::ROT_SIN_RST;
            r_y_scale   <= chm_pkg::Y_SCALE_RST;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_cnt <= '0;
            else r_cnt <= r_cnt + CNT_W'(1);

            if (w_ram_we) begin
                r_total <= w_new_total;
                if (r_slot == SLOT_LAST) begin
                    r_slot   <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end

            if (w_out_load) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    chm_pkg::CFG_OFFSET_X: r_offset_x <= i_cfg_wdata;
                    chm_pkg::CFG_OFFSET_Y: r_offset_y <= i_cfg_wdata;
                    chm_pkg::CFG_ROT_COS:  r_rot_cos  <= i_cfg_wdata;
                    chm_pkg::CFG_ROT_SIN:  r_rot_sin  <= i_cfg_wdata;
                    chm_pkg::CFG_Y_SCALE:  r_y_scale  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_dx <= chm_pkg::DIFF_W'($signed(s_axis_tdata[15:0])) - chm_pkg::DIFF_W'(r_offset_x);
            r_dy <= chm_pkg::DIFF_W'($signed(s_axis_tdata[31:16])) - chm_pkg::DIFF_W'(r_offset_y);
        end

        case (r_state)
            chm_pkg::ST_MUL: begin
                r_prod <= w_prod;
                // Each product is registered in r_prod and accumulated in the following cycle.
                case (r_cnt)
                    MS_DY_COS: r_acc_y <= chm_pkg::ACC_W'(r_prod);
                    MS_DX_COS: r_acc_y <= r_acc_y + chm_pkg::ACC_W'(r_prod);
                    MS_DY_SIN: r_acc_x <= chm_pkg::ACC_W'(r_prod);
                    MS_SCALE:  r_acc_x <= r_acc_x - chm_pkg::ACC_W'(r_prod);
                    MS_LAST: begin
                        r_re <= chm_pkg::VEC_W'(w_prod_shr);
                        r_im <= chm_pkg::VEC_W'(r_acc_x);
                    end
                    default: begin
                    end
                endcase
            end
            chm_pkg::ST_PREP: begin
                if (r_re < 0) begin
                    r_re  <= -r_re;
                    r_im  <= -r_im;
                    r_ang <= (r_im >= 0) ? HALF_ANG : -HALF_ANG;
                end else begin
                    r_ang <= '0;
                end
            end
            chm_pkg::ST_CORDIC: begin
                if (r_im >= 0) begin
                    r_re  <= r_re + w_sh_im;
                    r_im  <= r_im - w_sh_re;
                    r_ang <= r_ang + w_atan;
                end else begin
                    r_re  <= r_re - w_sh_im;
                    r_im  <= r_im + w_sh_re;
                    r_ang <= r_ang - w_atan;
                end
            end
            chm_pkg::ST_FINISH: begin
                r_now <= chm_pkg::DATA_W'(w_units_wrap);
            end
            chm_pkg::ST_DIV: begin
                // The total was updated at the previous edge.
                r_quo <= w_mean_prod[RECIP_SHIFT +: QUO_W];
            end
            default: begin
            end
        endcase

        if (w_out_load) begin
            r_out_now  <= r_now;
            r_out_mean <= r_quo;
        end
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_mean, r_out_now};

    `CHM_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tdata[15:0] < chm_pkg::FULL_TURN) && (m_axis_tdata[31:16] < chm_pkg::FULL_TURN),
        "heading or mean outside one full turn")
    `CHM_ASSERT_NEXT(a_hold_when_stalled, i_clk, i_rst_n,
        (r_state == chm_pkg::ST_DONE) && m_axis_tvalid && !m_axis_tready,
        (r_state == chm_pkg::ST_DONE), "result step left while output register was full")
    `CHM_ASSERT_NEXT(a_slot_advance, i_clk, i_rst_n, (r_state == chm_pkg::ST_UPDATE),
        (r_slot == (($past(r_slot) == SLOT_LAST) ? '0 : $past(r_slot) + SLOT_W'(1))),
        "window slot did not advance by one")
    `CHM_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1, (r_total <= TOTAL_MAX),
        "window total exceeds the window holding only maximum headings")

endmodule
